// ===== hw/rtl/skit_pkg.sv =====
// Shared types and codes for the sorted key index table.
package skit_pkg;

	localparam logic [1:0] MODE_LOOKUP   = 2'd0;
	localparam logic [1:0] MODE_INSERT   = 2'd1;
	localparam logic [1:0] MODE_SET_TAIL = 2'd2;
	localparam logic [1:0] MODE_READ     = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_EXISTS    = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] dimension;
		logic [31:0] data_kind;
		logic [63:0] head_address;
		logic [63:0] tail_address;
		logic [5:0]  entry_index;
	} skit_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [6:0]  position;
		logic [63:0] head_out;
		logic [63:0] tail_out;
		logic [6:0]  entry_count;
	} skit_rsp_t;

	typedef struct packed {
		logic [31:0] dimension;
		logic [31:0] data_kind;
		logic [63:0] head;
		logic [63:0] tail;
	} skit_entry_t;

endpackage

// ===== hw/rtl/skit_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transfer.
interface skit_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/skit_ram.sv =====
// Generic simple dual-port RAM with registered read.
module skit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== hw/rtl/sorted_key_index_table_unit.sv =====
// Sorted key index table: keyed lookup, sorted insert, tail update and indexed read.
//
// Holds up to TABLE_CAPACITY entries sorted by (dimension, data_kind), all in one
// RAM with one read and one write port, so every probe or move costs one RAM
// access. One item is processed at a time; a finished result sits in the output
// register while the next item is taken. A lookup is a binary search, one RAM
// read per probe, ending with a read of the located entry; an insert then moves
// each entry from the insert position upward by one slot (n - position moves
// with n entries held) and writes the new entry there. Set-tail and read access
// the indexed entry directly; an index out of range, or a null tail for
// set-tail, is rejected. The table is empty after reset; no clearing pass is run.
module sorted_key_index_table_unit #(
	parameter int TABLE_CAPACITY = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	skit_stream_if.sink   req,
	skit_stream_if.source rsp,
	input  logic         cfg_wr_en,
	input  logic [63:0]  cfg_wr_data
);
	import skit_pkg::*;

	localparam int IW   = $clog2(TABLE_CAPACITY);
	localparam int CW   = $clog2(TABLE_CAPACITY + 1);
	localparam int CMPW = (CW > 6) ? CW : 6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_PROBE,
		S_CMP,
		S_CHECK,
		S_SHIFT,
		S_PLACE,
		S_DONE
	} state_t;

	state_t      state_q;
	skit_req_t   req_q;
	skit_rsp_t   res_q;
	skit_rsp_t   out_q;
	logic        out_valid_q;
	logic [63:0] null_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] first_q;
	logic [CW-1:0] span_q;
	logic [IW-1:0] mid_q;
	logic [IW-1:0] shift_q;

	logic              rd_en;
	logic [IW-1:0]     rd_addr;
	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	skit_entry_t       wr_entry;
	logic [$bits(skit_entry_t)-1:0] rd_raw;
	skit_entry_t       rd_entry;

	logic [IW-1:0] mid_c;
	logic below_c, key_eq_c, hit_c, null_ins_c, full_c, shift_need_c, idx_bad_c;
	logic shift_more_c;
	logic out_load_c;
	logic [2:0] disp_status_c;
	skit_rsp_t out_c;

	assign rd_entry = rd_raw;

	assign mid_c = IW'(first_q + (span_q >> 1));
	assign below_c = (rd_entry.dimension < req_q.dimension) ||
		(rd_entry.dimension == req_q.dimension && rd_entry.data_kind < req_q.data_kind);
	assign key_eq_c = (rd_entry.dimension == req_q.dimension) &&
		(rd_entry.data_kind == req_q.data_kind);
	assign hit_c = (first_q < count_q) && key_eq_c;
	assign null_ins_c = (req_q.head_address == null_q) || (req_q.tail_address == null_q);
	assign full_c = count_q >= CW'(TABLE_CAPACITY);
	assign shift_need_c = count_q > first_q;
	assign idx_bad_c = CMPW'(req_q.entry_index) >= CMPW'(count_q);
	assign shift_more_c = CW'(shift_q) > (first_q + CW'(1));
	assign out_load_c = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		disp_status_c = ST_OK;
		if (req_q.mode == MODE_SET_TAIL &&
			(idx_bad_c || req_q.tail_address == null_q)) begin
			disp_status_c = ST_INVALID;
		end else if (req_q.mode == MODE_READ && idx_bad_c) begin
			disp_status_c = ST_NOT_FOUND;
		end
	end

	always_comb begin
		out_c             = res_q;
		out_c.entry_count = 7'(count_q);
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_entry = '0;
		unique case (state_q)
			S_DISPATCH: begin
				if (req_q.mode == MODE_SET_TAIL || req_q.mode == MODE_READ) begin
					rd_en   = 1'b1;
					rd_addr = IW'(req_q.entry_index);
				end
			end
			S_PROBE: begin
				rd_en   = 1'b1;
				rd_addr = (span_q == '0) ? IW'(first_q) : mid_c;
			end
			S_CHECK: begin
				if (req_q.mode == MODE_SET_TAIL) begin
					wr_en    = 1'b1;
					wr_addr  = IW'(req_q.entry_index);
					wr_entry = '{rd_entry.dimension, rd_entry.data_kind, rd_entry.head,
						req_q.tail_address};
				end else if (req_q.mode == MODE_INSERT && !null_ins_c && !hit_c &&
					!full_c && shift_need_c) begin
					rd_en   = 1'b1;
					rd_addr = IW'(count_q - CW'(1));
				end
			end
			S_SHIFT: begin
				wr_en    = 1'b1;
				wr_addr  = shift_q;
				wr_entry = rd_entry;
				rd_en    = shift_more_c;
				rd_addr  = (shift_q - IW'(1)) - IW'(1);
			end
			S_PLACE: begin
				wr_en    = 1'b1;
				wr_addr  = IW'(first_q);
				wr_entry = '{req_q.dimension, req_q.data_kind, req_q.head_address,
					req_q.tail_address};
			end
			default: begin
			end
		endcase
	end

	skit_ram #(
		.WIDTH($bits(skit_entry_t)),
		.DEPTH(TABLE_CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			null_q      <= '1;
			count_q     <= '0;
			first_q     <= '0;
			span_q      <= '0;
			mid_q       <= '0;
			shift_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				null_q <= cfg_wr_data;
			end
			if (out_load_c) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q   <= req.data;
						first_q <= '0;
						span_q  <= count_q;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					res_q.status   <= disp_status_c;
					res_q.found    <= 1'b0;
					res_q.position <= 7'(req_q.entry_index);
					res_q.head_out <= null_q;
					res_q.tail_out <= null_q;
					unique case (req_q.mode)
						MODE_LOOKUP, MODE_INSERT: begin
							state_q <= S_PROBE;
						end
						MODE_SET_TAIL, MODE_READ: begin
							if (disp_status_c != ST_OK) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_CHECK;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_PROBE: begin
					if (span_q == '0) begin
						state_q <= S_CHECK;
					end else begin
						mid_q   <= mid_c;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (below_c) begin
						first_q <= CW'(mid_q) + CW'(1);
						span_q  <= span_q - (span_q >> 1) - CW'(1);
					end else begin
						span_q <= span_q >> 1;
					end
					state_q <= S_PROBE;
				end
				S_CHECK: begin
					state_q <= S_DONE;
					unique case (req_q.mode)
						MODE_LOOKUP: begin
							res_q.found    <= hit_c;
							res_q.position <= 7'(first_q);
							if (hit_c) begin
								res_q.head_out <= rd_entry.head;
								res_q.tail_out <= rd_entry.tail;
							end else begin
								res_q.status <= ST_NOT_FOUND;
							end
						end
						MODE_INSERT: begin
							res_q.found    <= hit_c;
							res_q.position <= 7'(first_q);
							if (null_ins_c) begin
								res_q.status <= ST_INVALID;
							end else if (hit_c) begin
								res_q.status   <= ST_EXISTS;
								res_q.head_out <= rd_entry.head;
								res_q.tail_out <= rd_entry.tail;
							end else if (full_c) begin
								res_q.status <= ST_FULL;
							end else begin
								res_q.head_out <= req_q.head_address;
								res_q.tail_out <= req_q.tail_address;
								if (shift_need_c) begin
									shift_q <= IW'(count_q);
									state_q <= S_SHIFT;
								end else begin
									state_q <= S_PLACE;
								end
							end
						end
						MODE_SET_TAIL: begin
							res_q.head_out <= rd_entry.head;
							res_q.tail_out <= req_q.tail_address;
						end
						MODE_READ: begin
							res_q.head_out <= rd_entry.head;
							res_q.tail_out <= rd_entry.tail;
						end
						default: begin
						end
					endcase
				end
				S_SHIFT: begin
					if (shift_more_c) begin
						shift_q <= shift_q - IW'(1);
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load_c) begin
						out_q   <= out_c;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
